[hw/rtl/dsur_pkg.sv]
// Package for the rotating data stack: command and status codes, widths, depth.
// No dependencies.
package dsur_pkg;
	localparam int STACK_DEPTH = 16;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int DW = 64;

	localparam logic [3:0] CMD_PUSH = 4'd0;
	localparam logic [3:0] CMD_ADD  = 4'd1;
	localparam logic [3:0] CMD_SUB  = 4'd2;
	localparam logic [3:0] CMD_MUL  = 4'd3;
	localparam logic [3:0] CMD_DIV  = 4'd4;
	localparam logic [3:0] CMD_DUP  = 4'd5;
	localparam logic [3:0] CMD_SWAP = 4'd6;
	localparam logic [3:0] CMD_OUTN = 4'd7;
	localparam logic [3:0] CMD_OUTC = 4'd8;
	localparam logic [3:0] CMD_ROL  = 4'd9;
	localparam logic [3:0] CMD_ROR  = 4'd10;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_NUM  = 2'd1;
	localparam logic [1:0] KIND_CHAR = 2'd2;

	typedef struct packed {
		logic          start;
		logic [1:0]    op;
		logic [DW-1:0] a;
		logic [DW-1:0] b;
	} dsur_alu_req_t;

	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_DIV = 2'd1;
endpackage

[hw/rtl/dsur_ram.sv]
// Generic one-write, one-read synchronous RAM with registered read data.
// No dependencies.
module dsur_ram #(
	parameter int AW = 4,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/dsur_muldiv.sv]
// Multicycle 64-bit unit: 16x64 partial-product multiply, restoring signed divide.
// Uses dsur_pkg.
module dsur_muldiv (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dsur_pkg::dsur_alu_req_t      req,
	output logic                         done,
	output logic [dsur_pkg::DW-1:0]      res
);
	localparam int DW = dsur_pkg::DW;

	logic          busy_q;
	logic          isdiv_q;
	logic [6:0]    cnt_q;
	logic [DW-1:0] acc_q;
	logic [DW-1:0] mcand_q;
	logic [DW-1:0] mplier_q;
	logic [DW-1:0] rem_q;
	logic          neg_q;
	logic [DW:0]   trial;
	logic [DW-1:0] ua, ub;

	assign ua = req.a[DW-1] ? -req.a : req.a;
	assign ub = req.b[DW-1] ? -req.b : req.b;
	assign trial = {rem_q, mplier_q[DW-1]} - {1'b0, mcand_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == dsur_pkg::OP_DIV) ? 7'd64 : 7'd4;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			isdiv_q <= (req.op == dsur_pkg::OP_DIV);
			acc_q   <= '0;
			rem_q   <= '0;
			neg_q   <= req.a[DW-1] ^ req.b[DW-1];
			if (req.op == dsur_pkg::OP_DIV) begin
				mcand_q  <= ua;
				mplier_q <= ub;
			end else begin
				mcand_q  <= req.b;
				mplier_q <= req.a;
			end
		end else if (busy_q) begin
			if (isdiv_q) begin
				if (!trial[DW]) begin
					rem_q    <= trial[DW-1:0];
					mplier_q <= {mplier_q[DW-2:0], 1'b1};
				end else begin
					rem_q    <= {rem_q[DW-2:0], mplier_q[DW-1]};
					mplier_q <= {mplier_q[DW-2:0], 1'b0};
				end
			end else begin
				acc_q    <= acc_q + DW'(mcand_q * {48'd0, mplier_q[15:0]});
				mcand_q  <= {mcand_q[DW-17:0], 16'd0};
				mplier_q <= {16'd0, mplier_q[DW-1:16]};
			end
		end
	end

	assign res = isdiv_q ? (neg_q ? -mplier_q : mplier_q) : acc_q;
endmodule

[hw/rtl/data_stack_unit_with_rotate_core.sv]
// Top level of the rotating data stack: sequencer around a stack RAM and muldiv unit.
// Uses dsur_pkg, dsur_ram, dsur_muldiv.
// Push is answered from idle; others read operands in S_RD0 and S_RD1, then run S_EXEC
// and S_OUT, or leave after S_RD0 if rejected. Swap adds S_WB2, mul and a nonzero div
// add S_WAIT. One command at a time; next beat taken once the result register is free.
// Reset clears count, bottom pointer and control; RAM contents are undefined until written.
module data_stack_unit_with_rotate_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // [3:0] command, [67:4] in_value, [71:68] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [63:0] out_value, [65:64] status, [70:66] stack_depth,
	                              // [71] zero
	output logic [1:0]  m_tuser   // [1:0] out_kind
);
	localparam int AW = dsur_pkg::AW;
	localparam int CW = dsur_pkg::CW;
	localparam int DW = dsur_pkg::DW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD0  = 3'd1;
	localparam logic [2:0] S_RD1  = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_WB2  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]    state_q;
	logic [3:0]    cmd_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] bot_q;
	logic [DW-1:0] a_q, b_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [DW-1:0] wdata, rdata;
	logic [AW-1:0] top_slot, sec_slot, new_slot, bot_m1;
	dsur_pkg::dsur_alu_req_t req;
	logic          md_done;
	logic [DW-1:0] md_res;
	logic [1:0]    kind_q, status_q;
	logic [DW-1:0] oval_q;

	assign top_slot = bot_q + AW'(cnt_q - CW'(1));
	assign sec_slot = bot_q + AW'(cnt_q - CW'(2));
	assign new_slot = bot_q + AW'(cnt_q);
	assign bot_m1   = bot_q - AW'(1);

	dsur_ram #(.AW(AW), .DW(DW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	dsur_muldiv u_md (.clk(clk), .arst_n(arst_n), .req(req), .done(md_done), .res(md_res));

	logic need2, need1;
	assign need2 = cmd_q inside {dsur_pkg::CMD_ADD, dsur_pkg::CMD_SUB, dsur_pkg::CMD_MUL,
		dsur_pkg::CMD_DIV, dsur_pkg::CMD_SWAP};
	assign need1 = cmd_q inside {dsur_pkg::CMD_DUP, dsur_pkg::CMD_OUTN, dsur_pkg::CMD_OUTC,
		dsur_pkg::CMD_ROL, dsur_pkg::CMD_ROR};

	always_comb begin
		raddr = top_slot;
		if (state_q == S_RD0 && cmd_q == dsur_pkg::CMD_ROR)
			raddr = bot_q;
		else if (state_q == S_RD0)
			raddr = sec_slot;
	end

	always_comb begin
		we    = 1'b0;
		waddr = top_slot;
		wdata = a_q;
		req   = '0;
		req.a = a_q;
		req.b = b_q;
		if (state_q == S_EXEC) begin
			case (cmd_q)
				dsur_pkg::CMD_ADD: begin
					we = 1'b1; waddr = sec_slot; wdata = b_q + a_q;
				end
				dsur_pkg::CMD_SUB: begin
					we = 1'b1; waddr = sec_slot; wdata = b_q - a_q;
				end
				dsur_pkg::CMD_MUL: begin
					req.start = 1'b1; req.op = dsur_pkg::OP_MUL;
				end
				dsur_pkg::CMD_DIV: begin
					req.start = (a_q != '0); req.op = dsur_pkg::OP_DIV;
				end
				dsur_pkg::CMD_SWAP: begin
					we = 1'b1; waddr = top_slot; wdata = b_q;
				end
				dsur_pkg::CMD_DUP: begin
					we = 1'b1; waddr = new_slot; wdata = a_q;
				end
				dsur_pkg::CMD_ROL: begin
					we = 1'b1; waddr = bot_m1; wdata = a_q;
				end
				dsur_pkg::CMD_ROR: begin
					we = 1'b1; waddr = new_slot; wdata = b_q;
				end
				default: ;
			endcase
		end else if (state_q == S_WAIT && md_done) begin
			we = 1'b1; waddr = sec_slot; wdata = md_res;
		end else if (state_q == S_WB2) begin
			we = 1'b1; waddr = sec_slot; wdata = a_q;
		end else if (state_q == S_IDLE && s_tvalid && s_tready && s_tdata[3:0] ==
			dsur_pkg::CMD_PUSH && cnt_q < CW'(dsur_pkg::STACK_DEPTH)) begin
			we = 1'b1; waddr = new_slot; wdata = s_tdata[67:4];
		end
	end

	assign s_tready = (state_q == S_IDLE) && !m_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			bot_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_tvalid && s_tready) begin
					if (s_tdata[3:0] == dsur_pkg::CMD_PUSH) begin
						if (cnt_q < CW'(dsur_pkg::STACK_DEPTH))
							cnt_q <= cnt_q + CW'(1);
						m_tvalid <= 1'b1;
					end else
						state_q <= S_RD0;
				end
				S_RD0: begin
					if ((need2 && cnt_q < CW'(2)) || (need1 && cnt_q == '0) ||
						(cmd_q == dsur_pkg::CMD_DUP &&
						cnt_q == CW'(dsur_pkg::STACK_DEPTH)) || (!need1 && !need2)) begin
						state_q  <= S_IDLE;
						m_tvalid <= 1'b1;
					end else
						state_q <= S_RD1;
				end
				S_RD1: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= S_OUT;
					case (cmd_q)
						dsur_pkg::CMD_ADD, dsur_pkg::CMD_SUB: cnt_q <= cnt_q - CW'(1);
						dsur_pkg::CMD_MUL: state_q <= S_WAIT;
						dsur_pkg::CMD_DIV: if (a_q != '0) state_q <= S_WAIT;
						dsur_pkg::CMD_SWAP: state_q <= S_WB2;
						dsur_pkg::CMD_DUP: cnt_q <= cnt_q + CW'(1);
						dsur_pkg::CMD_OUTN, dsur_pkg::CMD_OUTC: cnt_q <= cnt_q - CW'(1);
						dsur_pkg::CMD_ROL: bot_q <= bot_m1;
						dsur_pkg::CMD_ROR: bot_q <= bot_q + AW'(1);
						default: ;
					endcase
				end
				S_WAIT: if (md_done) begin
					cnt_q   <= cnt_q - CW'(1);
					state_q <= S_OUT;
				end
				S_WB2: state_q <= S_OUT;
				S_OUT: begin
					m_tvalid <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ror writes the old bottom one past the old top, which is the top after the bump
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid && s_tready) begin
			cmd_q    <= s_tdata[3:0];
			kind_q   <= dsur_pkg::KIND_NONE;
			oval_q   <= '0;
			status_q <= (s_tdata[3:0] == dsur_pkg::CMD_PUSH &&
				cnt_q >= CW'(dsur_pkg::STACK_DEPTH)) ? dsur_pkg::ST_OVER : dsur_pkg::ST_OK;
		end
		if (state_q == S_RD0) begin
			if ((need2 && cnt_q < CW'(2)) || (need1 && cnt_q == '0))
				status_q <= dsur_pkg::ST_UNDER;
			else if (cmd_q == dsur_pkg::CMD_DUP && cnt_q == CW'(dsur_pkg::STACK_DEPTH))
				status_q <= dsur_pkg::ST_OVER;
			a_q <= rdata;
		end
		if (state_q == S_RD1)
			b_q <= rdata;
		if (state_q == S_EXEC) begin
			if (cmd_q == dsur_pkg::CMD_DIV && a_q == '0)
				status_q <= dsur_pkg::ST_DIVZ;
			if (cmd_q == dsur_pkg::CMD_OUTN) begin
				kind_q <= dsur_pkg::KIND_NUM; oval_q <= a_q;
			end
			if (cmd_q == dsur_pkg::CMD_OUTC) begin
				kind_q <= dsur_pkg::KIND_CHAR; oval_q <= a_q;
			end
		end
	end

	assign m_tdata = {1'b0, 5'(cnt_q), status_q, oval_q};
	assign m_tuser = kind_q;

	ap_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(dsur_pkg::STACK_DEPTH))
		else $error("stack count beyond depth");
	ap_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !m_tvalid)
		else $error("result shown while command in flight");
	ap_md_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == S_WAIT))
		else $error("muldiv done outside wait");
endmodule

[tb/tb_data_stack_unit_with_rotate_core.sv]
// Testbench for data_stack_unit_with_rotate_core: directed and random command streams,
// checked beat by beat against an in-bench stack predictor. Depends on dsur_pkg and the RTL.
module tb_data_stack_unit_with_rotate_core;
	typedef struct packed {
		logic [3:0]  cmd;
		logic [63:0] val;
	} cmd_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] value;
		logic [1:0]  status;
		logic [4:0]  depth;
	} stack_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;

	data_stack_unit_with_rotate_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	cmd_beat_t     pending_cmds[$];
	stack_result_t expected_results[$];
	int            mismatch_count = 0;
	bit            stim_done = 1'b0;
	bit            hold_armed = 1'b0;
	bit            hold_taken = 1'b0;
	int            hold_cycles = 0;

	// predictor state
	logic [63:0] pred_store[dsur_pkg::STACK_DEPTH];
	int          pred_count = 0;
	int          pred_bottom = 0;
	int          model_count = 0; // depth tracked while generating stimulus

	function automatic int slot_at(int pos);
		return (pred_bottom + pos) % dsur_pkg::STACK_DEPTH;
	endfunction

	function automatic logic [63:0] signed_quotient(logic [63:0] n, logic [63:0] d);
		logic [63:0] un, ud, q;
		un = n[63] ? -n : n;
		ud = d[63] ? -d : d;
		q = un / ud;
		return (n[63] != d[63]) ? -q : q;
	endfunction

	task automatic predict_stack(cmd_beat_t c);
		stack_result_t r;
		logic [63:0] a, b, v;
		r = '0;
		case (c.cmd)
			dsur_pkg::CMD_PUSH: begin
				if (pred_count >= dsur_pkg::STACK_DEPTH) r.status = dsur_pkg::ST_OVER;
				else begin
					pred_count++;
					pred_store[slot_at(pred_count - 1)] = c.val;
				end
			end
			dsur_pkg::CMD_ADD, dsur_pkg::CMD_SUB, dsur_pkg::CMD_MUL, dsur_pkg::CMD_DIV,
			dsur_pkg::CMD_SWAP: begin
				if (pred_count < 2) r.status = dsur_pkg::ST_UNDER;
				else begin
					a = pred_store[slot_at(pred_count - 1)];
					b = pred_store[slot_at(pred_count - 2)];
					if (c.cmd == dsur_pkg::CMD_SWAP) begin
						pred_store[slot_at(pred_count - 1)] = b;
						pred_store[slot_at(pred_count - 2)] = a;
					end else if (c.cmd == dsur_pkg::CMD_DIV && a == 0)
						r.status = dsur_pkg::ST_DIVZ;
					else begin
						case (c.cmd)
							dsur_pkg::CMD_ADD: v = b + a;
							dsur_pkg::CMD_SUB: v = b - a;
							dsur_pkg::CMD_MUL: v = b * a;
							default: v = signed_quotient(b, a);
						endcase
						pred_count--;
						pred_store[slot_at(pred_count - 1)] = v;
					end
				end
			end
			dsur_pkg::CMD_DUP: begin
				if (pred_count < 1) r.status = dsur_pkg::ST_UNDER;
				else if (pred_count >= dsur_pkg::STACK_DEPTH) r.status = dsur_pkg::ST_OVER;
				else begin
					a = pred_store[slot_at(pred_count - 1)];
					pred_count++;
					pred_store[slot_at(pred_count - 1)] = a;
				end
			end
			dsur_pkg::CMD_OUTN, dsur_pkg::CMD_OUTC: begin
				if (pred_count < 1) r.status = dsur_pkg::ST_UNDER;
				else begin
					r.value = pred_store[slot_at(pred_count - 1)];
					r.kind = (c.cmd == dsur_pkg::CMD_OUTN) ? dsur_pkg::KIND_NUM :
						dsur_pkg::KIND_CHAR;
					pred_count--;
				end
			end
			dsur_pkg::CMD_ROL: begin
				if (pred_count < 1) r.status = dsur_pkg::ST_UNDER;
				else begin
					a = pred_store[slot_at(pred_count - 1)];
					pred_bottom = (pred_bottom + dsur_pkg::STACK_DEPTH - 1) %
						dsur_pkg::STACK_DEPTH;
					pred_store[pred_bottom] = a;
				end
			end
			dsur_pkg::CMD_ROR: begin
				if (pred_count < 1) r.status = dsur_pkg::ST_UNDER;
				else begin
					a = pred_store[slot_at(0)];
					pred_bottom = (pred_bottom + 1) % dsur_pkg::STACK_DEPTH;
					pred_store[slot_at(pred_count - 1)] = a;
				end
			end
			default: ;
		endcase
		r.depth = pred_count[4:0];
		expected_results.push_back(r);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatch_count++;
		$display("MISMATCH %s: got %h expected %h", what, got, want);
	endtask

	// queue a command, tracking depth so random traffic stays well-formed
	task automatic add_cmd(logic [3:0] cmd, logic [63:0] val);
		cmd_beat_t c;
		c.cmd = cmd;
		c.val = val;
		pending_cmds.push_back(c);
		case (cmd)
			dsur_pkg::CMD_PUSH: if (model_count < dsur_pkg::STACK_DEPTH) model_count++;
			dsur_pkg::CMD_DUP:
				if (model_count >= 1 && model_count < dsur_pkg::STACK_DEPTH) model_count++;
			dsur_pkg::CMD_ADD, dsur_pkg::CMD_SUB, dsur_pkg::CMD_MUL, dsur_pkg::CMD_DIV:
				if (model_count >= 2) model_count--;
			dsur_pkg::CMD_OUTN, dsur_pkg::CMD_OUTC: if (model_count >= 1) model_count--;
			default: ;
		endcase
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return 64'hffff_ffff_ffff_ffff;
			3: return 64'(0);
			4: return {$urandom, $urandom};
			default: return 64'($signed($urandom_range(0, 40)) - 20);
		endcase
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		int g;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_stack(pending_cmds.pop_front());
				g = $urandom_range(0, 15);
				if (g == 0 && pending_cmds.size() > 0) begin
					s_tdata <= {4'b0, pending_cmds[0].val, pending_cmds[0].cmd};
				end else begin
					s_tvalid <= 1'b0;
					send_gap <= g;
				end
			end else if (!s_tvalid) begin
				if (send_gap > 0)
					send_gap <= send_gap - 1;
				else if (pending_cmds.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, pending_cmds[0].val, pending_cmds[0].cmd};
				end
			end
		end
	end

	// monitor
	int recv_gap = 0;
	always @(posedge clk) begin
		stack_result_t want;
		int g;
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata[63:0], 64'(0));
			end else begin
				want = expected_results.pop_front();
				if (m_tuser[1:0] !== want.kind)
					report_mismatch("out_kind", 64'(m_tuser[1:0]), 64'(want.kind));
				if (m_tdata[63:0] !== want.value)
					report_mismatch("out_value", m_tdata[63:0], want.value);
				if (m_tdata[65:64] !== want.status)
					report_mismatch("status", 64'(m_tdata[65:64]), 64'(want.status));
				if (m_tdata[70:66] !== want.depth)
					report_mismatch("stack_depth", 64'(m_tdata[70:66]), 64'(want.depth));
			end
			g = $urandom_range(0, 15);
			recv_gap <= g;
			m_tready <= (g == 0) && (hold_cycles == 0);
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_armed && !hold_taken) begin
			hold_cycles <= 300;
			hold_taken <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	initial begin
		int k, op, burst;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: underflow on empty stack for every command other than push
		for (k = 1; k <= 10; k++) add_cmd(4'(k), 64'(0));
		add_cmd(4'd11, 64'h5);
		add_cmd(4'd15, '1);
		add_cmd(dsur_pkg::CMD_PUSH, 64'h8000_0000_0000_0000);
		add_cmd(dsur_pkg::CMD_ROL, 64'(0));
		add_cmd(dsur_pkg::CMD_ROR, 64'(0));
		add_cmd(dsur_pkg::CMD_PUSH, 64'hffff_ffff_ffff_ffff);
		add_cmd(dsur_pkg::CMD_DIV, 64'(0));
		add_cmd(dsur_pkg::CMD_PUSH, 64'(0));
		add_cmd(dsur_pkg::CMD_DIV, 64'(0));
		add_cmd(dsur_pkg::CMD_OUTN, 64'(0));
		add_cmd(dsur_pkg::CMD_OUTC, 64'(0));
		for (k = 0; k < 17; k++)
			add_cmd(dsur_pkg::CMD_PUSH, 64'h7fff_ffff_ffff_ff00 + 64'(k));
		add_cmd(dsur_pkg::CMD_DUP, 64'(0));
		add_cmd(dsur_pkg::CMD_ROL, 64'(0));
		add_cmd(dsur_pkg::CMD_ROR, 64'(0));
		add_cmd(dsur_pkg::CMD_SWAP, 64'(0));
		add_cmd(dsur_pkg::CMD_MUL, 64'(0));
		add_cmd(dsur_pkg::CMD_SUB, 64'(0));
		add_cmd(dsur_pkg::CMD_ADD, 64'(0));

		// hold off the receiver while push and rol commands are queued for the sender
		wait (pending_cmds.size() == 0);
		hold_armed = 1'b1;
		for (k = 0; k < 20; k++)
			add_cmd($urandom_range(0, 1) ? dsur_pkg::CMD_PUSH : dsur_pkg::CMD_ROL, rand_value());

		// random: mostly well-formed bursts, some noise
		k = 0;
		while (k < 590) begin
			burst = $urandom_range(0, 9);
			if (burst < 7) begin
				if (model_count < 2 || (model_count < dsur_pkg::STACK_DEPTH &&
					$urandom_range(0, 2) == 0))
					add_cmd(dsur_pkg::CMD_PUSH, rand_value());
				else begin
					op = $urandom_range(1, 10);
					add_cmd(4'(op), 64'(0));
				end
			end else begin
				add_cmd(4'($urandom_range(0, 15)), rand_value());
			end
			k++;
		end
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done && pending_cmds.size() == 0 && !s_tvalid && expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#(12 * 600000);
		$display("end of test: mismatches");
		$finish;
	end
endmodule
